FILE: sv/dic_pkg.sv
// Shared types, constants and the cosine basis function for the dequant/IDCT core.
// No dependencies; imported by dic_ctrl, dic_datapath and the top level.
package dic_pkg;

   localparam int COS_FRAC_BITS_DEF = 14;
   localparam int TABLE_FRAC        = 30;
   localparam int COEF_W            = 12;
   localparam int QUANT_W           = 8;
   localparam int PROD_W            = 20;   // coefficient times quant entry
   localparam int PIX_W             = 8;
   localparam int IDX_W             = 6;
   localparam int REQ_DATA_W        = 24;   // 20 payload bits padded to bytes
   localparam int RSP_DATA_W        = 16;   // 14 payload bits padded to bytes

   // cos(k*pi/16), k = 0..8, 30 fraction bits
   localparam longint COS_Q30 [9] = '{
      64'sd1073741824, 64'sd1053110176, 64'sd992008094, 64'sd892783698,
      64'sd759250125,  64'sd596538995,  64'sd410903207, 64'sd209476638,
      64'sd0
   };

   localparam logic PASS_ROW = 1'b0;   // store -> intermediate memory
   localparam logic PASS_COL = 1'b1;   // intermediate memory -> pixel

   // One multiply-accumulate term issued by the controller.
   typedef struct packed {
      logic             valid;
      logic             pass;
      logic [IDX_W-1:0] addr;    // read address in store or intermediate memory
      logic [2:0]       n;       // basis sample position
      logic [2:0]       k;       // basis frequency
      logic             first;
      logic             last;
      logic [IDX_W-1:0] idx;     // result index
   } dic_cmd_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
   } dic_load_type;

   typedef struct packed {
      logic row_done;   // last intermediate value written
      logic pix_done;   // pixel placed in the output register
      logic out_full;   // output register holds an untaken word
   } dic_status_type;

   // Basis factor c(k)*cos((2n+1)k*pi/16) with cfb fraction bits.
   function automatic longint dic_basis(input logic [2:0] n, input logic [2:0] k,
                                        input int cfb);
      logic [6:0] prod;
      logic [4:0] m;
      longint     mag;
      longint     r;
      logic       neg;
      int         sh;
      sh   = TABLE_FRAC - cfb;
      prod = {3'b000, n, 1'b1} * {4'b0000, k};
      m    = prod[4:0];
      neg  = 1'b0;
      if (k == 3'd0) begin
         mag = COS_Q30[4];
      end else if (m <= 5'd8) begin
         mag = COS_Q30[m[3:0]];
      end else if (m <= 5'd16) begin
         mag = COS_Q30[4'(5'd16 - m)];
         neg = 1'b1;
      end else if (m <= 5'd24) begin
         mag = COS_Q30[4'(m - 5'd16)];
         neg = 1'b1;
      end else begin
         mag = COS_Q30[4'(6'd32 - {1'b0, m})];
      end
      r = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return neg ? -r : r;
   endfunction

endpackage

FILE: sv/dic_ctrl.sv
// Sequencer for the dequant/IDCT core: load, row pass, column pass per pixel.
// Depends on dic_pkg; drives dic_datapath through command structs.
module dic_ctrl
   import dic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  dic_status_type status,
   output dic_load_type   load,
   output dic_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD, ST_ROW, ST_ROW_WAIT, ST_COL_CHECK, ST_COL_RUN, ST_COL_WAIT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;   // load count, then output index
   logic [2:0]       j_ff;     // term within a sum
   dic_cmd_type      cmd_ff;

   assign in_ready  = (state_ff == ST_LOAD);
   assign load.we   = in_valid && in_ready;
   assign load.addr = cnt_ff;
   assign cmd       = cmd_ff;

   always_ff @(posedge clock) begin
      cmd_ff.valid <= !reset && ((state_ff == ST_ROW) || (state_ff == ST_COL_RUN));
      cmd_ff.first <= (j_ff == 3'd0);
      cmd_ff.last  <= (j_ff == 3'd7);
      cmd_ff.idx   <= cnt_ff;
      cmd_ff.k     <= j_ff;
      if (state_ff == ST_ROW) begin
         cmd_ff.pass <= PASS_ROW;
         cmd_ff.addr <= {cnt_ff[5:3], j_ff};
         cmd_ff.n    <= cnt_ff[2:0];
      end else begin
         cmd_ff.pass <= PASS_COL;
         cmd_ff.addr <= {j_ff, cnt_ff[2:0]};
         cmd_ff.n    <= cnt_ff[5:3];
      end
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         j_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (load.we) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  j_ff   <= '0;
                  if (cnt_ff == 6'd63) state_ff <= ST_ROW;
               end
            end
            ST_ROW: begin
               j_ff <= j_ff + 1'b1;
               if (j_ff == 3'd7) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == 6'd63) state_ff <= ST_ROW_WAIT;
               end
            end
            ST_ROW_WAIT: begin
               if (status.row_done) state_ff <= ST_COL_CHECK;
            end
            ST_COL_CHECK: begin
               j_ff <= '0;
               if (!status.out_full) state_ff <= ST_COL_RUN;
            end
            ST_COL_RUN: begin
               j_ff <= j_ff + 1'b1;
               if (j_ff == 3'd7) state_ff <= ST_COL_WAIT;
            end
            ST_COL_WAIT: begin
               if (status.pix_done) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == 6'd63) state_ff <= ST_LOAD;
                  else                 state_ff <= ST_COL_CHECK;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

FILE: sv/dic_datapath.sv
// Datapath of the dequant/IDCT core: coefficient store, intermediate memory,
// pipelined multiply-accumulate, pixel rounding/clamp and output register. Uses dic_pkg.
module dic_datapath
   import dic_pkg::*;
#(
   parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  dic_load_type              load,
   input  logic signed [COEF_W-1:0]  coefficient,
   input  logic        [QUANT_W-1:0] quant_value,
   input  dic_cmd_type               cmd,
   output dic_status_type            status,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [PIX_W-1:0]          pixel,
   output logic [IDX_W-1:0]          pixel_index,
   output logic                      last_of_block
);

   localparam int FW = COS_FRAC_BITS + 2;        // basis factor width
   localparam int TW = FW + PROD_W + 3;          // intermediate sum width
   localparam int SW = 2 * FW + PROD_W + 6;      // final sum width
   localparam int SH = 2 * COS_FRAC_BITS + 2;    // combined scale shift
   localparam int LO = 20;                       // low slice of intermediate
   localparam int HW = TW - LO;
   localparam int QW = SW - SH;

   logic signed [PROD_W-1:0] store [64];
   logic signed [TW-1:0]     tmem  [64];

   logic signed [PROD_W-1:0] st_rd_ff;
   logic signed [TW-1:0]     tm_rd_ff;
   logic signed [FW-1:0]     f_ff;
   logic signed [FW-1:0]     f_in;
   longint                   bas;
   dic_cmd_type              ca_ff, cb_ff, cc_ff, cd_ff;

   logic signed [PROD_W+FW-1:0]   p1_ff;
   logic signed [LO+1+FW-1:0]     plo_ff;
   logic signed [HW+FW-1:0]       phi_ff;
   logic signed [SW-1:0]          term_ff;
   logic signed [SW-1:0]          acc_ff;

   logic signed [SW-1:0] adj;
   logic signed [QW-1:0] q;
   logic [PIX_W-1:0]     pix_in;
   logic                 res_row, res_col;

   logic                 out_valid_ff;
   logic [PIX_W-1:0]     pixel_ff;
   logic [IDX_W-1:0]     index_ff;

   always_comb begin
      bas  = dic_basis(cmd.n, cmd.k, COS_FRAC_BITS);
      f_in = bas[FW-1:0];
   end

   // stores and read stage
   always_ff @(posedge clock) begin
      if (load.we) store[load.addr] <= PROD_W'(coefficient) *
                                       PROD_W'($signed({1'b0, quant_value}));
      if (res_row) tmem[cd_ff.idx] <= acc_ff[TW-1:0];
      st_rd_ff <= store[cmd.addr];
      tm_rd_ff <= tmem[cmd.addr];
      f_ff     <= f_in;
   end

   // multiply, combine, accumulate
   always_ff @(posedge clock) begin
      p1_ff   <= st_rd_ff * f_ff;
      plo_ff  <= $signed({1'b0, tm_rd_ff[LO-1:0]}) * f_ff;
      phi_ff  <= $signed(tm_rd_ff[TW-1:LO]) * f_ff;
      if (cb_ff.pass == PASS_COL) term_ff <= (SW'(phi_ff) <<< LO) + SW'(plo_ff);
      else                        term_ff <= SW'(p1_ff);
      if (cc_ff.first) acc_ff <= term_ff;
      else             acc_ff <= acc_ff + term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff.valid <= 1'b0;
         cb_ff.valid <= 1'b0;
         cc_ff.valid <= 1'b0;
         cd_ff.valid <= 1'b0;
      end else begin
         ca_ff <= cmd;
         cb_ff <= ca_ff;
         cc_ff <= cb_ff;
         cd_ff <= cc_ff;
      end
   end

   assign res_row = cd_ff.valid && cd_ff.last && (cd_ff.pass == PASS_ROW);
   assign res_col = cd_ff.valid && cd_ff.last && (cd_ff.pass == PASS_COL);

   // truncate toward zero, level shift, clamp
   always_comb begin
      adj = acc_ff + (acc_ff[SW-1] ? SW'((64'sd1 <<< SH) - 64'sd1) : SW'(0));
      q   = QW'(adj >>> SH);
      if (q < -QW'(128))     pix_in = '0;
      else if (q > QW'(127)) pix_in = '1;
      else                   pix_in = PIX_W'(q + QW'(128));
   end

   always_ff @(posedge clock) begin
      if (res_col) begin
         pixel_ff <= pix_in;
         index_ff <= cd_ff.idx;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_col) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.row_done = res_row && (cd_ff.idx == 6'd63);
   assign status.pix_done = res_col;
   assign status.out_full = out_valid_ff;

   assign out_valid     = out_valid_ff;
   assign pixel         = pixel_ff;
   assign pixel_index   = index_ff;
   assign last_of_block = (index_ff == 6'd63);

endmodule

FILE: sv/dequant_idct_8x8_block_core.sv
// Top level of the 8x8 dequantization and inverse DCT core.
// Depends on dic_pkg, dic_ctrl and dic_datapath.
//
// Feed the 64 quantized coefficients of a block in row-major order, each with
// its quantization entry; one word is taken per cycle while the core is
// loading. After the 64th word the core runs a separable inverse DCT on a
// single multiply-accumulate pipeline: a row pass of 512 terms (one per
// cycle, then the pipeline drain) into a 64-entry intermediate memory, then
// a column pass that builds one pixel at a time from 8 terms and waits for
// the pipeline to drain before it starts the next. Sums are exact, scaled by
// 1/4 and the basis scale, truncated toward zero, shifted by 128 and
// clamped to 0..255. Pixels leave in row-major order with rsp_tlast on the
// 64th; the output register holds one pixel, and the next pixel is not
// started until that one has been taken, so a receiver stall holds up the
// column pass. No new block is taken until the last pixel of the current
// one has been computed.
module dequant_idct_8x8_block_core
   import dic_pkg::*;
#(
   parameter int COS_FRAC_BITS = COS_FRAC_BITS_DEF   // basis fraction bits, 10..18
)
(
   input  logic                  clock,
   input  logic                  reset,
   // coefficient stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] coefficient, [19:12] quant_value
   // pixel stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] pixel, [13:8] pixel_index
   output logic                  rsp_tlast    // last_of_block
);

   dic_status_type   status;
   dic_load_type     load;
   dic_cmd_type      cmd;
   logic [PIX_W-1:0] pixel;
   logic [IDX_W-1:0] pixel_index;

   dic_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .load     (load),
      .cmd      (cmd)
   );

   dic_datapath #(
      .COS_FRAC_BITS (COS_FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .coefficient   ($signed(req_tdata[COEF_W-1:0])),
      .quant_value   (req_tdata[COEF_W+QUANT_W-1:COEF_W]),
      .cmd           (cmd),
      .status        (status),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .pixel         (pixel),
      .pixel_index   (pixel_index),
      .last_of_block (rsp_tlast)
   );

   // unused upper tdata bits are zero
   assign rsp_tdata = {2'b00, pixel_index, pixel};

endmodule

FILE: test/tb.sv
// Testbench for dequant_idct_8x8_block_core: streams blocks of coefficient words and
// checks every pixel word against a local 2-D inverse DCT predictor. Depends on dic_pkg.
module tb
   import dic_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CFB       = COS_FRAC_BITS_DEF;
   localparam int IDLE_LIM  = 20000;   // covers a full block of work under heavy stall

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [IDX_W-1:0] index;
      logic             last;
   } pixel_word_type;

   typedef enum {
      PAT_MAX, PAT_MIN, PAT_DC, PAT_ZERO, PAT_ALT, PAT_RAND, PAT_JPEG
   } pattern_type;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   dequant_idct_8x8_block_core dut (.*);

   // predictor state
   longint            products [64];
   int                load_pos;
   longint            factor [8][8];
   pixel_word_type    pixels_due [$];
   int                fail_count;
   int                send_idle_pct, recv_stall_pct;
   int                idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // basis c(k)cos((2n+1)k pi/16), rounded half away from zero
   function automatic longint basis_factor(int n, int k);
      int     m, sh;
      longint mag;
      bit     neg;
      sh  = TABLE_FRAC - CFB;
      m   = ((2 * n + 1) * k) % 32;
      neg = 0;
      if (k == 0)        mag = COS_Q30[4];
      else if (m <= 8)   mag = COS_Q30[m];
      else if (m <= 16) begin mag = COS_Q30[16 - m]; neg = 1; end
      else if (m <= 24) begin mag = COS_Q30[m - 16]; neg = 1; end
      else               mag = COS_Q30[32 - m];
      mag = (mag + (longint'(1) << (sh - 1))) >> sh;
      return neg ? -mag : mag;
   endfunction

   task automatic predict_block();
      longint sum, v;
      int     sh;
      pixel_word_type w;
      sh = 2 * CFB + 2;
      for (int i = 0; i < 64; i++) begin
         sum = 0;
         for (int x = 0; x < 8; x++)
            for (int y = 0; y < 8; y++)
               sum += products[x*8+y] * factor[i/8][x] * factor[i%8][y];
         v = (sum < 0) ? -((-sum) >>> sh) : (sum >>> sh);
         v += 128;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         w.pixel = v[7:0];
         w.index = i[5:0];
         w.last  = (i == 63);
         pixels_due = {pixels_due, w};
      end
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // one coefficient word; prediction happens on acceptance
   task automatic send_coef(logic signed [COEF_W-1:0] coef, logic [QUANT_W-1:0] quant);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, quant, coef};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      products[load_pos] = longint'(coef) * longint'(quant);
      if (load_pos == 63) begin
         load_pos = 0;
         predict_block();
      end else load_pos++;
      @(negedge clock);
   endtask

   task automatic send_block(pattern_type mode);
      logic signed [COEF_W-1:0] c;
      logic [QUANT_W-1:0] q;
      for (int i = 0; i < 64; i++) begin
         case (mode)
            PAT_MAX:  begin c = 12'sh7ff; q = 8'hff; end
            PAT_MIN:  begin c = 12'sh800; q = 8'hff; end
            PAT_DC:   begin c = (i == 0) ? 12'sh7ff : 12'sh0; q = 8'hff; end
            PAT_ZERO: begin c = 12'sh0; q = 8'h0; end
            PAT_ALT:  begin c = (i % 2) ? 12'sh800 : 12'sh7ff; q = 8'hff; end
            PAT_RAND: begin c = 12'($urandom); q = 8'($urandom); end
            default: begin   // JPEG-like: DC plus few small AC terms
               c = (i == 0) ? 12'($signed($urandom_range(0, 200)) - 100)
                  : (($urandom_range(3) == 0) ? 12'($signed($urandom_range(0, 40)) - 20)
                                              : 12'sh0);
               q = 8'($urandom_range(1, 64));
            end
         endcase
         send_coef(c, q);
      end
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pixels_due.size() != 0) @(negedge clock);
   endtask

   task automatic test_extremes();
      send_idle_pct = 0; recv_stall_pct = 0;
      send_block(PAT_MAX);
      send_block(PAT_MIN);
   endtask

   task automatic test_random(int blocks, int sp, int rp);
      send_idle_pct = sp; recv_stall_pct = rp;
      for (int b = 0; b < blocks; b++)
         send_block(($urandom_range(2) == 0) ? PAT_RAND : PAT_JPEG);
   endtask

   task automatic test_hold_off();
      send_idle_pct = 0; recv_stall_pct = 17;
      send_block(PAT_JPEG);
      wait_drain();
      send_block(PAT_ALT);
   endtask

   // receiver stall
   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

   // result checker and watchdog
   always @(posedge clock) begin
      pixel_word_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIM) begin
            $display("status: fail");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[13:8], rsp_tlast};
            if (pixels_due.size() == 0) report_mismatch("pixel word with none expected");
            else begin
               want = pixels_due.pop_front();
               if (got.pixel !== want.pixel)
                  report_mismatch($sformatf("pixel %0d: got %0d want %0d",
                                            want.index, got.pixel, want.pixel));
               if (got.index !== want.index)
                  report_mismatch($sformatf("index got %0d want %0d", got.index, want.index));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last at %0d got %b", want.index, got.last));
            end
         end
      end
   end

   initial begin
      req_tvalid = 1'b0; req_tdata = '0;
      reset = 1'b1; load_pos = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      for (int n = 0; n < 8; n++)
         for (int k = 0; k < 8; k++) factor[n][k] = basis_factor(n, k);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_random(1, 85, 0);
      test_random(1, 0, 85);
      test_random(1, 17, 17);
      test_hold_off();
      wait_drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pixels_due.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
